FILE: src/ptq_pkg.sv
// ---------------------------------------------------------------------------
// ptq_pkg
// Shared types and constants of the point table query block.
// ---------------------------------------------------------------------------
`default_nettype none

package ptq_pkg;

    localparam int FIELD_W = 24;
    localparam int KEY_W   = 8;
    localparam int MODE_W  = 3;
    localparam int RAD_W   = 23;
    localparam int DIST_W  = 50;

    localparam int DEF_TABLE_SLOTS = 64;
    localparam int DEF_COORD_BITS  = 24;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD     = 3'd0,
        MODE_SET     = 3'd1,
        MODE_LOOKUP  = 3'd2,
        MODE_NEAREST = 3'd3,
        MODE_RADIUS  = 3'd4,
        MODE_CLEAR   = 3'd5
    } mode_t;

    // control tag that travels with each slot read through the distance pipe
    typedef struct packed {
        logic live;
        logic occupied;
    } scan_tag_t;

endpackage

`default_nettype wire

FILE: src/ptq_in_if.sv
// ---------------------------------------------------------------------------
// ptq_in_if
// Request channel: mode, key and query or entry data.
// ---------------------------------------------------------------------------
`default_nettype none

interface ptq_in_if;
    import ptq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [MODE_W-1:0]         mode;
    logic [KEY_W-1:0]          key_id;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] pos_z;
    logic                      open_flag;
    logic [RAD_W-1:0]          search_radius;

    modport source (
        output valid, mode, key_id, pos_x, pos_y, pos_z, open_flag, search_radius,
        input  ready
    );
    modport sink (
        input  valid, mode, key_id, pos_x, pos_y, pos_z, open_flag, search_radius,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/ptq_out_if.sv
// ---------------------------------------------------------------------------
// ptq_out_if
// Result channel: one word per reported entry or status.
// ---------------------------------------------------------------------------
`default_nettype none

interface ptq_out_if;
    import ptq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      found;
    logic                      changed;
    logic                      table_full;
    logic [KEY_W-1:0]          entry_id;
    logic                      entry_open;
    logic signed [FIELD_W-1:0] entry_x;
    logic signed [FIELD_W-1:0] entry_y;
    logic signed [FIELD_W-1:0] entry_z;
    logic [DIST_W-1:0]         dist_squared;
    logic                      last;

    modport source (
        output valid, found, changed, table_full, entry_id, entry_open,
               entry_x, entry_y, entry_z, dist_squared, last,
        input  ready
    );
    modport sink (
        input  valid, found, changed, table_full, entry_id, entry_open,
               entry_x, entry_y, entry_z, dist_squared, last,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/point_table_nearest_and_radius_query.sv
// ---------------------------------------------------------------------------
// point_table_nearest_and_radius_query
// Keyed 3D point table with add, set, lookup, nearest and radius queries.
// ---------------------------------------------------------------------------
// Entries live in one RAM of TABLE_SLOTS words. Occupancy lives in a second,
// one bit wide RAM that a wipe pass clears after reset and for the clear
// mode, so the input is held off after reset until the wipe pass is done.
// Add, set, lookup and nearest stream all slots once through the RAM read
// ports and a three stage distance pipe. A radius query with h hits makes
// h + 1 such passes, emitting hits in ascending id. Each result is held in
// the decide state until the previous word has been taken from the output
// register. A new request is taken only once the previous one has finished;
// the result register lets the last result wait without holding up the next
// request.
`default_nettype none

module point_table_nearest_and_radius_query import ptq_pkg::*; #(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
    parameter int COORD_BITS  = DEF_COORD_BITS
) (
    input  logic     clk,
    input  logic     rst_n,
    ptq_in_if.sink   req,
    ptq_out_if.source rsp
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int ENT_W = KEY_W + 1 + 3 * COORD_BITS;
    localparam int RR_W  = 2 * RAD_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIPE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } state_t;

    state_t state_reg;

    logic [MODE_W-1:0]            mode_reg;
    logic [KEY_W-1:0]             key_reg;
    logic                         open_reg;
    logic signed [COORD_BITS-1:0] qx_reg, qy_reg, qz_reg;
    logic [RR_W-1:0]              rr_reg;
    logic [IDX_W-1:0]             addr_reg;
    logic [1:0]                   drain_reg;
    logic                         live_s1_reg;
    logic [IDX_W-1:0]             idx_s1_reg;
    logic                         first_reg;
    logic [KEY_W-1:0]             prev_key_reg;

    logic                         sel_hit_reg;
    logic [IDX_W-1:0]             sel_idx_reg;
    logic [KEY_W-1:0]             sel_key_reg;
    logic                         sel_open_reg;
    logic signed [COORD_BITS-1:0] sel_x_reg, sel_y_reg, sel_z_reg;
    logic [DIST_W-1:0]            sel_d_reg;
    logic                         free_hit_reg;
    logic [IDX_W-1:0]             free_idx_reg;

    logic                         pend_valid_reg;
    logic [KEY_W-1:0]             pend_key_reg;
    logic                         pend_open_reg;
    logic signed [COORD_BITS-1:0] pend_x_reg, pend_y_reg, pend_z_reg;
    logic [DIST_W-1:0]            pend_d_reg;

    logic                         out_valid_reg;
    logic                         out_found_reg;
    logic                         out_changed_reg;
    logic                         out_full_reg;
    logic [KEY_W-1:0]             out_id_reg;
    logic                         out_open_reg;
    logic signed [FIELD_W-1:0]    out_x_reg, out_y_reg, out_z_reg;
    logic [DIST_W-1:0]            out_d_reg;
    logic                         out_last_reg;

    // RAMs and pipe
    logic [ENT_W-1:0]             rdata;
    logic                         ram_we;
    logic [IDX_W-1:0]             wr_idx;
    logic [ENT_W-1:0]             wr_data;
    logic                         wipe;
    logic                         vram_we;
    logic [IDX_W-1:0]             vram_waddr;
    logic                         vram_wdata;
    logic                         vram_rdata;
    scan_tag_t                    s1_tag;

    scan_tag_t                    d_tag;
    logic [IDX_W-1:0]             d_idx;
    logic [KEY_W-1:0]             d_key;
    logic                         d_open;
    logic signed [COORD_BITS-1:0] d_x, d_y, d_z;
    logic [DIST_W-1:0]            d_dist;

    logic in_fire;
    logic out_free;
    logic occ, key_match, better_near, in_radius, better_rad, take, free_take;

    logic                         res_emit;
    logic                         res_found, res_changed, res_full, res_last;
    logic [KEY_W-1:0]             res_key;
    logic                         res_open;
    logic signed [COORD_BITS-1:0] res_x, res_y, res_z;
    logic [DIST_W-1:0]            res_d;
    logic                         do_write;
    logic                         rescan;
    logic                         go;

    ptq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx),
        .wdata (wr_data),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    // occupancy marks, read alongside the entry RAM
    ptq_ram #(
        .WIDTH (1),
        .DEPTH (TABLE_SLOTS)
    ) u_vram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (vram_waddr),
        .wdata (vram_wdata),
        .raddr (addr_reg),
        .rdata (vram_rdata)
    );

    assign wipe       = (state_reg == ST_WIPE);
    assign vram_we    = wipe || ram_we;
    assign vram_waddr = wipe ? addr_reg : wr_idx;
    assign vram_wdata = !wipe;
    assign s1_tag     = '{live: live_s1_reg, occupied: vram_rdata};

    ptq_dist #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .COORD_BITS  (COORD_BITS)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .qx       (qx_reg),
        .qy       (qy_reg),
        .qz       (qz_reg),
        .in_tag   (s1_tag),
        .in_idx   (idx_s1_reg),
        .in_key   (rdata[ENT_W-1 -: KEY_W]),
        .in_open  (rdata[3*COORD_BITS]),
        .in_x     (rdata[3*COORD_BITS-1 -: COORD_BITS]),
        .in_y     (rdata[2*COORD_BITS-1 -: COORD_BITS]),
        .in_z     (rdata[COORD_BITS-1:0]),
        .out_tag  (d_tag),
        .out_idx  (d_idx),
        .out_key  (d_key),
        .out_open (d_open),
        .out_x    (d_x),
        .out_y    (d_y),
        .out_z    (d_z),
        .out_dist (d_dist)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign in_fire   = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // per slot selection as words leave the distance pipe
    assign occ         = d_tag.live && d_tag.occupied;
    assign key_match   = occ && (d_key == key_reg);
    assign better_near = occ && (!sel_hit_reg || (d_dist < sel_d_reg) ||
                         ((d_dist == sel_d_reg) && (d_key < sel_key_reg)));
    assign in_radius   = occ && (d_dist <= DIST_W'(rr_reg));
    assign better_rad  = in_radius && (first_reg || (d_key > prev_key_reg)) &&
                         (!sel_hit_reg || (d_key < sel_key_reg));
    assign free_take   = d_tag.live && !d_tag.occupied && !free_hit_reg;

    always_comb
    begin
        unique case (mode_reg)
            MODE_ADD, MODE_SET, MODE_LOOKUP: take = key_match;
            MODE_NEAREST:                    take = better_near;
            MODE_RADIUS:                     take = better_rad;
            default:                         take = 1'b0;
        endcase
    end

    // outcome of a finished pass
    always_comb
    begin
        res_emit    = 1'b1;
        res_found   = 1'b0;
        res_changed = 1'b0;
        res_full    = 1'b0;
        res_last    = 1'b1;
        res_key     = '0;
        res_open    = 1'b0;
        res_x       = '0;
        res_y       = '0;
        res_z       = '0;
        res_d       = '0;
        do_write    = 1'b0;
        wr_idx      = sel_idx_reg;
        wr_data     = {sel_key_reg, open_reg, sel_x_reg, sel_y_reg, sel_z_reg};
        rescan      = 1'b0;
        unique case (mode_reg)
            MODE_ADD:
            begin
                if (sel_hit_reg || free_hit_reg)
                begin
                    do_write  = 1'b1;
                    wr_idx    = sel_hit_reg ? sel_idx_reg : free_idx_reg;
                    wr_data   = {key_reg, open_reg, qx_reg, qy_reg, qz_reg};
                    res_found = 1'b1;
                    res_key   = key_reg;
                    res_open  = open_reg;
                    res_x     = qx_reg;
                    res_y     = qy_reg;
                    res_z     = qz_reg;
                end
                else
                begin
                    res_full = 1'b1;
                end
            end
            MODE_SET:
            begin
                if (sel_hit_reg)
                begin
                    do_write    = 1'b1;
                    res_found   = 1'b1;
                    res_changed = sel_open_reg ^ open_reg;
                    res_key     = sel_key_reg;
                    res_open    = open_reg;
                    res_x       = sel_x_reg;
                    res_y       = sel_y_reg;
                    res_z       = sel_z_reg;
                end
            end
            MODE_LOOKUP, MODE_NEAREST:
            begin
                if (sel_hit_reg)
                begin
                    res_found = 1'b1;
                    res_key   = sel_key_reg;
                    res_open  = sel_open_reg;
                    res_x     = sel_x_reg;
                    res_y     = sel_y_reg;
                    res_z     = sel_z_reg;
                    res_d     = (mode_reg == MODE_NEAREST) ? sel_d_reg : '0;
                end
            end
            MODE_RADIUS:
            begin
                // hold one hit back so the last flag can go on the final one
                rescan   = sel_hit_reg;
                res_emit = pend_valid_reg || !sel_hit_reg;
                res_last = !sel_hit_reg;
                if (pend_valid_reg)
                begin
                    res_found = 1'b1;
                    res_key   = pend_key_reg;
                    res_open  = pend_open_reg;
                    res_x     = pend_x_reg;
                    res_y     = pend_y_reg;
                    res_z     = pend_z_reg;
                    res_d     = pend_d_reg;
                end
            end
            MODE_CLEAR:
            begin
                res_found = 1'b1;
            end
            default:
            begin
                res_emit = 1'b0;
            end
        endcase
    end

    assign go     = (state_reg == ST_DECIDE) && (out_free || !res_emit);
    assign ram_we = go && do_write;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_WIPE;
            mode_reg        <= '0;
            key_reg         <= '0;
            open_reg        <= 1'b0;
            qx_reg          <= '0;
            qy_reg          <= '0;
            qz_reg          <= '0;
            rr_reg          <= '0;
            addr_reg        <= '0;
            drain_reg       <= '0;
            live_s1_reg     <= 1'b0;
            idx_s1_reg      <= '0;
            first_reg       <= 1'b0;
            prev_key_reg    <= '0;
            sel_hit_reg     <= 1'b0;
            sel_idx_reg     <= '0;
            sel_key_reg     <= '0;
            sel_open_reg    <= 1'b0;
            sel_x_reg       <= '0;
            sel_y_reg       <= '0;
            sel_z_reg       <= '0;
            sel_d_reg       <= '0;
            free_hit_reg    <= 1'b0;
            free_idx_reg    <= '0;
            pend_valid_reg  <= 1'b0;
            pend_key_reg    <= '0;
            pend_open_reg   <= 1'b0;
            pend_x_reg      <= '0;
            pend_y_reg      <= '0;
            pend_z_reg      <= '0;
            pend_d_reg      <= '0;
            out_valid_reg   <= 1'b0;
            out_found_reg   <= 1'b0;
            out_changed_reg <= 1'b0;
            out_full_reg    <= 1'b0;
            out_id_reg      <= '0;
            out_open_reg    <= 1'b0;
            out_x_reg       <= '0;
            out_y_reg       <= '0;
            out_z_reg       <= '0;
            out_d_reg       <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready && !(go && res_emit))
            begin
                out_valid_reg <= 1'b0;
            end

            live_s1_reg <= (state_reg == ST_SCAN);
            idx_s1_reg  <= addr_reg;

            if (take)
            begin
                sel_hit_reg  <= 1'b1;
                sel_idx_reg  <= d_idx;
                sel_key_reg  <= d_key;
                sel_open_reg <= d_open;
                sel_x_reg    <= d_x;
                sel_y_reg    <= d_y;
                sel_z_reg    <= d_z;
                sel_d_reg    <= d_dist;
            end
            if (free_take)
            begin
                free_hit_reg <= 1'b1;
                free_idx_reg <= d_idx;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire && (req.mode <= MODE_CLEAR))
                    begin
                        mode_reg       <= req.mode;
                        key_reg        <= req.key_id;
                        open_reg       <= req.open_flag;
                        qx_reg         <= req.pos_x[COORD_BITS-1:0];
                        qy_reg         <= req.pos_y[COORD_BITS-1:0];
                        qz_reg         <= req.pos_z[COORD_BITS-1:0];
                        rr_reg         <= RR_W'(req.search_radius) * RR_W'(req.search_radius);
                        addr_reg       <= '0;
                        first_reg      <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        sel_hit_reg    <= 1'b0;
                        free_hit_reg   <= 1'b0;
                        state_reg      <= (req.mode == MODE_CLEAR) ? ST_WIPE : ST_SCAN;
                    end
                end
                ST_WIPE:
                begin
                    // one occupancy mark cleared per cycle
                    if (addr_reg == IDX_W'(TABLE_SLOTS - 1))
                    begin
                        addr_reg  <= '0;
                        state_reg <= (mode_reg == MODE_CLEAR) ? ST_DECIDE : ST_IDLE;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
                ST_SCAN:
                begin
                    if (addr_reg == IDX_W'(TABLE_SLOTS - 1))
                    begin
                        drain_reg <= 2'd3;
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    if (drain_reg == 2'd0)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                    else
                    begin
                        drain_reg <= drain_reg - 1'b1;
                    end
                end
                ST_DECIDE:
                begin
                    if (go)
                    begin
                        if (res_emit)
                        begin
                            out_valid_reg   <= 1'b1;
                            out_found_reg   <= res_found;
                            out_changed_reg <= res_changed;
                            out_full_reg    <= res_full;
                            out_id_reg      <= res_key;
                            out_open_reg    <= res_open;
                            out_x_reg       <= FIELD_W'(res_x);
                            out_y_reg       <= FIELD_W'(res_y);
                            out_z_reg       <= FIELD_W'(res_z);
                            out_d_reg       <= res_d;
                            out_last_reg    <= res_last;
                        end
                        if (rescan)
                        begin
                            pend_valid_reg <= 1'b1;
                            pend_key_reg   <= sel_key_reg;
                            pend_open_reg  <= sel_open_reg;
                            pend_x_reg     <= sel_x_reg;
                            pend_y_reg     <= sel_y_reg;
                            pend_z_reg     <= sel_z_reg;
                            pend_d_reg     <= sel_d_reg;
                            prev_key_reg   <= sel_key_reg;
                            first_reg      <= 1'b0;
                            sel_hit_reg    <= 1'b0;
                            free_hit_reg   <= 1'b0;
                            addr_reg       <= '0;
                            state_reg      <= ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.found        = out_found_reg;
    assign rsp.changed      = out_changed_reg;
    assign rsp.table_full   = out_full_reg;
    assign rsp.entry_id     = out_id_reg;
    assign rsp.entry_open   = out_open_reg;
    assign rsp.entry_x      = out_x_reg;
    assign rsp.entry_y      = out_y_reg;
    assign rsp.entry_z      = out_z_reg;
    assign rsp.dist_squared = out_d_reg;
    assign rsp.last         = out_last_reg;

    // unused modes leave the block idle with no result
    a_unused_mode_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (req.mode > MODE_CLEAR)) |=> (state_reg == ST_IDLE))
        else $error("unused mode left idle");

    // only a radius query produces a word that is not the last
    a_not_last_radius: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> (mode_reg == MODE_RADIUS))
        else $error("non-final word outside radius query");

    // a miss reports no entry data
    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_found_reg) |-> ((out_id_reg == '0) && (out_d_reg == '0)))
        else $error("miss carries entry data");

    // table writes happen only at the end of a pass
    a_write_decide: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_DECIDE))
        else $error("table write outside decide");

endmodule

`default_nettype wire

FILE: src/ptq_ram.sv
// ---------------------------------------------------------------------------
// ptq_ram
// Generic simple dual port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module ptq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: src/ptq_dist.sv
// ---------------------------------------------------------------------------
// ptq_dist
// Three stage squared distance pipe: abs difference, square, sum.
// ---------------------------------------------------------------------------
`default_nettype none

module ptq_dist import ptq_pkg::*; #(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
    parameter int COORD_BITS  = DEF_COORD_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic signed [COORD_BITS-1:0]     qx,
    input  logic signed [COORD_BITS-1:0]     qy,
    input  logic signed [COORD_BITS-1:0]     qz,
    input  scan_tag_t                        in_tag,
    input  logic [$clog2(TABLE_SLOTS)-1:0]   in_idx,
    input  logic [KEY_W-1:0]                 in_key,
    input  logic                             in_open,
    input  logic signed [COORD_BITS-1:0]     in_x,
    input  logic signed [COORD_BITS-1:0]     in_y,
    input  logic signed [COORD_BITS-1:0]     in_z,
    output scan_tag_t                        out_tag,
    output logic [$clog2(TABLE_SLOTS)-1:0]   out_idx,
    output logic [KEY_W-1:0]                 out_key,
    output logic                             out_open,
    output logic signed [COORD_BITS-1:0]     out_x,
    output logic signed [COORD_BITS-1:0]     out_y,
    output logic signed [COORD_BITS-1:0]     out_z,
    output logic [DIST_W-1:0]                out_dist
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int ABS_W = COORD_BITS + 1;
    localparam int SQ_W  = 2 * ABS_W;
    localparam int SUM_W = SQ_W + 2;
    localparam int ENT_W = KEY_W + 1 + 3 * COORD_BITS;

    logic signed [ABS_W-1:0] dx, dy, dz;
    logic [ABS_W-1:0]        ax, ay, az;

    scan_tag_t        tag1_reg, tag2_reg, tag3_reg;
    logic [IDX_W-1:0] idx1_reg, idx2_reg, idx3_reg;
    logic [ENT_W-1:0] ent1_reg, ent2_reg, ent3_reg;
    logic [ABS_W-1:0] ax_reg, ay_reg, az_reg;
    logic [SQ_W-1:0]  sqx_reg, sqy_reg, sqz_reg;
    logic [SUM_W-1:0] sum_reg;

    assign dx = ABS_W'(in_x) - ABS_W'(qx);
    assign dy = ABS_W'(in_y) - ABS_W'(qy);
    assign dz = ABS_W'(in_z) - ABS_W'(qz);

    // most negative difference wraps to the right unsigned magnitude
    assign ax = dx[ABS_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
    assign ay = dy[ABS_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
    assign az = dz[ABS_W-1] ? ABS_W'(-dz) : ABS_W'(dz);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= in_idx;
        ent1_reg <= {in_key, in_open, in_x, in_y, in_z};
        ax_reg   <= ax;
        ay_reg   <= ay;
        az_reg   <= az;

        idx2_reg <= idx1_reg;
        ent2_reg <= ent1_reg;
        sqx_reg  <= SQ_W'(ax_reg) * SQ_W'(ax_reg);
        sqy_reg  <= SQ_W'(ay_reg) * SQ_W'(ay_reg);
        sqz_reg  <= SQ_W'(az_reg) * SQ_W'(az_reg);

        idx3_reg <= idx2_reg;
        ent3_reg <= ent2_reg;
        sum_reg  <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);
    end

    assign out_tag  = tag3_reg;
    assign out_idx  = idx3_reg;
    assign out_key  = ent3_reg[ENT_W-1 -: KEY_W];
    assign out_open = ent3_reg[3*COORD_BITS];
    assign out_x    = ent3_reg[3*COORD_BITS-1 -: COORD_BITS];
    assign out_y    = ent3_reg[2*COORD_BITS-1 -: COORD_BITS];
    assign out_z    = ent3_reg[COORD_BITS-1:0];
    assign out_dist = DIST_W'(sum_reg);

endmodule

`default_nettype wire
